// ===== rtl/hse_pkg.sv =====
`default_nettype none

package hse_pkg;

    // Width of the value field on both channels.
    localparam int unsigned VALUE_W = 64;

    typedef logic signed [VALUE_W-1:0] t_value;

    // Command codes of the input word.
    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_READ = 1'b1
    } t_cmd;

endpackage

`default_nettype wire

// ===== rtl/hse_if.sv =====
`default_nettype none

// Command channel: load or read.
interface hse_in_if;
    import hse_pkg::*;

    logic   valid;
    logic   ready;
    t_cmd   cmd;
    t_value value;
    logic   last;

    modport source (output valid, output cmd, output value, output last, input ready);
    modport sink   (input valid, input cmd, input value, input last, output ready);
endinterface

// Result channel: one word per read command.
interface hse_out_if;
    import hse_pkg::*;

    logic   valid;
    logic   ready;
    t_value value_res;
    logic   last_res;
    logic   empty_res;

    modport source (output valid, output value_res, output last_res, output empty_res,
                    input ready);
    modport sink   (input valid, input value_res, input last_res, input empty_res,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/hse_ram.sv =====
`default_nettype none

// Simple RAM: one write port, two registered read ports.
module hse_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic      [WIDTH-1:0]         o_rdata_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

// ===== rtl/heap_sort_engine_core.sv =====
`default_nettype none

// heap_sort_engine_core: collects signed values and hands them back in
// ascending order. A load word (cmd = CMD_LOAD) stores the low DATA_WIDTH
// bits of its value; loads beyond DEPTH entries are dropped. The load word
// flagged last starts an in-place heapsort in the store RAM: a max-heap is
// built by sift-down, then the root is swapped to the end of the heap and
// sifted down again until one entry is left. Read words (cmd = CMD_READ)
// each return one result word: the next value, sign-extended to 64 bits,
// with last_res on the final one; with nothing left (or before any set was
// closed) the result is zero with empty_res set. A load after reading has
// started drops the unread values and begins a new set. A load is written
// to the store as it is taken; a read waits on the registered RAM read
// port before its result word is registered. The sort holds off the
// command channel; each sift level uses the shared two-read/one-write
// store RAM (read both children, compare, write back). The store needs
// no clearing after reset: only entries written in the current set are
// ever read.
module heap_sort_engine_core #(
    parameter int unsigned DEPTH      = 1024,
    parameter int unsigned DATA_WIDTH = 64
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    hse_in_if.sink     i_cmd_if,
    hse_out_if.source  o_res_if
);

    import hse_pkg::*;

    localparam int unsigned IW = $clog2(DEPTH);      // store index
    localparam int unsigned CW = $clog2(DEPTH + 1);  // counts up to DEPTH
    localparam int unsigned KW = IW + 2;             // child index math

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_WT,
        S_BLD_RD,
        S_BLD_WT,
        S_KID_RD,
        S_KID_CMP,
        S_EXT_RD,
        S_EXT_WT
    } t_state;

    t_state                r_state;
    logic                  r_reading;   // set closed, reads return data
    logic                  r_building;  // heap build pass vs. extract pass
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         r_rd_idx;
    logic [IW-1:0]         r_bld_i;
    logic [IW-1:0]         r_ext_end;
    logic [CW-1:0]         r_hend;      // current heap size
    logic [IW-1:0]         r_root;      // hole being sifted
    logic [IW-1:0]         r_kid;       // left child of r_root
    logic                  r_has_r;     // right child lies inside the heap
    logic [DATA_WIDTH-1:0] r_val;       // value being sifted down
    logic                  r_rd_empty;
    logic                  r_rd_last;

    logic                  r_out_valid;
    t_value                r_out_value;
    logic                  r_out_last;
    logic                  r_out_empty;

    // Store RAM
    logic                  w_we;
    logic [IW-1:0]         w_waddr;
    logic [DATA_WIDTH-1:0] w_wdata;
    logic [IW-1:0]         w_raddr_a;
    logic [IW-1:0]         w_raddr_b;
    logic [DATA_WIDTH-1:0] w_rdata_a;
    logic [DATA_WIDTH-1:0] w_rdata_b;

    hse_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr_a),
        .o_rdata_a (w_rdata_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_b (w_rdata_b)
    );

    // Command handshake
    logic w_cmd_fire;
    logic w_is_load;
    logic w_res_fire;

    assign i_cmd_if.ready = (r_state == S_IDLE) && (!r_out_valid || o_res_if.ready);
    assign w_cmd_fire     = i_cmd_if.valid && i_cmd_if.ready;
    assign w_is_load      = (i_cmd_if.cmd == CMD_LOAD);
    assign w_res_fire     = o_res_if.valid && o_res_if.ready;

    // Load path: a load after reading restarts the set at entry 0.
    logic [CW-1:0] w_base;
    logic          w_room;
    logic [CW-1:0] w_new_count;

    assign w_base      = r_reading ? '0 : r_count;
    assign w_room      = (w_base < CW'(DEPTH));
    assign w_new_count = w_base + CW'(w_room);

    // Read path
    logic w_avail;
    assign w_avail = r_reading && (r_rd_idx < r_count);

    // Sift step: children of the hole
    logic [KW-1:0] w_kid_l;
    logic [KW-1:0] w_kid_r;
    logic          w_has_l;
    logic          w_pick_r;
    logic [DATA_WIDTH-1:0] w_big;
    logic [IW-1:0] w_big_idx;
    logic          w_sink;      // hole value smaller than the larger child

    assign w_kid_l   = {1'b0, r_root, 1'b1};
    assign w_kid_r   = w_kid_l + KW'(1);
    assign w_has_l   = (w_kid_l < KW'(r_hend));
    assign w_pick_r  = r_has_r && ($signed(w_rdata_a) < $signed(w_rdata_b));
    assign w_big     = w_pick_r ? w_rdata_b : w_rdata_a;
    assign w_big_idx = w_pick_r ? (r_kid + IW'(1)) : r_kid;
    assign w_sink    = ($signed(r_val) < $signed(w_big));

    // The settle of the hole ends this cycle.
    logic w_settled;
    assign w_settled = ((r_state == S_KID_RD) && !w_has_l) ||
                       ((r_state == S_KID_CMP) && !w_sink);

    // RAM port control
    always_comb begin
        w_we      = 1'b0;
        w_waddr   = r_root;
        w_wdata   = r_val;
        w_raddr_a = r_rd_idx[IW-1:0];
        w_raddr_b = r_ext_end;
        case (r_state)
            S_IDLE: begin
                w_we    = w_cmd_fire && w_is_load && w_room;
                w_waddr = w_base[IW-1:0];
                w_wdata = i_cmd_if.value[DATA_WIDTH-1:0];
            end
            S_BLD_RD: begin
                w_raddr_a = r_bld_i;
            end
            S_KID_RD: begin
                w_we      = !w_has_l;
                w_raddr_a = w_kid_l[IW-1:0];
                w_raddr_b = w_kid_r[IW-1:0];
            end
            S_KID_CMP: begin
                w_we    = 1'b1;
                w_wdata = w_sink ? w_big : r_val;
            end
            S_EXT_RD: begin
                w_raddr_a = '0;
            end
            S_EXT_WT: begin
                // old root goes to the end of the shrinking heap
                w_we    = 1'b1;
                w_waddr = r_ext_end;
                w_wdata = w_rdata_a;
            end
            default: begin
            end
        endcase
    end

    // Control and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_reading   <= 1'b0;
            r_building  <= 1'b0;
            r_count     <= '0;
            r_rd_idx    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_res_fire) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_cmd_fire && w_is_load) begin
                        r_count  <= w_new_count;
                        r_rd_idx <= '0;
                        if (i_cmd_if.last) begin
                            r_reading <= 1'b1;
                            if (w_new_count >= CW'(2)) begin
                                r_building <= 1'b1;
                                r_bld_i    <= IW'((w_new_count >> 1) - CW'(1));
                                r_state    <= S_BLD_RD;
                            end
                        end else begin
                            r_reading <= 1'b0;
                        end
                    end else if (w_cmd_fire) begin
                        r_rd_empty <= !w_avail;
                        r_rd_last  <= ((r_rd_idx + CW'(1)) == r_count);
                        if (w_avail) begin
                            r_rd_idx <= r_rd_idx + CW'(1);
                        end
                        r_state <= S_RD_WT;
                    end
                end
                S_RD_WT: begin
                    r_out_valid <= 1'b1;
                    r_out_value <= r_rd_empty ? '0 : VALUE_W'($signed(w_rdata_a));
                    r_out_last  <= !r_rd_empty && r_rd_last;
                    r_out_empty <= r_rd_empty;
                    r_state     <= S_IDLE;
                end
                S_BLD_RD: begin
                    r_state <= S_BLD_WT;
                end
                S_BLD_WT: begin
                    r_val   <= w_rdata_a;
                    r_root  <= r_bld_i;
                    r_hend  <= r_count;
                    r_state <= S_KID_RD;
                end
                S_KID_RD: begin
                    r_kid   <= w_kid_l[IW-1:0];
                    r_has_r <= (w_kid_r < KW'(r_hend));
                    if (w_has_l) begin
                        r_state <= S_KID_CMP;
                    end
                end
                S_KID_CMP: begin
                    if (w_sink) begin
                        r_root  <= w_big_idx;
                        r_state <= S_KID_RD;
                    end
                end
                S_EXT_RD: begin
                    r_state <= S_EXT_WT;
                end
                S_EXT_WT: begin
                    r_val   <= w_rdata_b;
                    r_root  <= '0;
                    r_hend  <= CW'(r_ext_end);
                    r_state <= S_KID_RD;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // next heap pass once the hole has settled
            if (w_settled) begin
                if (r_building) begin
                    if (r_bld_i == '0) begin
                        r_building <= 1'b0;
                        r_ext_end  <= IW'(r_count - CW'(1));
                        r_state    <= S_EXT_RD;
                    end else begin
                        r_bld_i <= r_bld_i - IW'(1);
                        r_state <= S_BLD_RD;
                    end
                end else if (r_ext_end == IW'(1)) begin
                    r_state <= S_IDLE;
                end else begin
                    r_ext_end <= r_ext_end - IW'(1);
                    r_state   <= S_EXT_RD;
                end
            end
        end
    end

    assign o_res_if.valid     = r_out_valid;
    assign o_res_if.value_res = r_out_value;
    assign o_res_if.last_res  = r_out_last;
    assign o_res_if.empty_res = r_out_empty;

`ifndef SYNTHESIS
    // The set never grows past the store.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("item count beyond store depth");

    // Reads never run past the loaded set.
    a_rd_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_idx <= r_count)
        else $error("read index beyond item count");

    // A read is taken only when the result register will be free.
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD_WT) |-> !r_out_valid)
        else $error("read result would overwrite a pending word");

    // Compared children always lie inside the heap.
    a_kid_in_heap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_KID_CMP) |-> (CW'(r_kid) < r_hend))
        else $error("sift child outside heap");
`endif

endmodule

`default_nettype wire
